// ===== hdl/rkc_pkg.sv =====
package rkc_pkg;

   // kernel and line geometry
   localparam int KERNEL_SIZE = 3;
   localparam int MAX_WIDTH   = 2048;
   localparam int HALF        = KERNEL_SIZE / 2;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

   // one spare row so the newest row never lands on a row still being read
   localparam int ROWS_KEPT   = KERNEL_SIZE + 1;
   localparam int STORE_DEPTH = ROWS_KEPT * MAX_WIDTH;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WID_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS    = 16;
   localparam int CNT_BITS    = WID_BITS + ROW_BITS;
   localparam int RM_BITS     = $clog2(ROWS_KEPT);
   localparam int RMX_BITS    = $clog2(2 * ROWS_KEPT + HALF);
   localparam int KI_BITS     = $clog2(KERNEL_SIZE);
   localparam int TAP_BITS    = $clog2(TAPS);

   // 8-bit signed coefficient times 9-bit pixel, summed over all taps
   localparam int SUM_BITS    = 17 + $clog2(TAPS) + 1;
   localparam int SCALE_BITS  = 17;
   localparam int PROD_BITS   = SUM_BITS - 1 + SCALE_BITS;
   localparam int PIX_BITS    = 24;

   localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(65536);

   typedef enum logic [2:0] {
      CSR_COEFF0 = 3'd0,
      CSR_COEFF1 = 3'd1,
      CSR_COEFF2 = 3'd2,
      CSR_COEFF3 = 3'd3,
      CSR_SCALE  = 3'd4,
      CSR_GREY   = 3'd5,
      CSR_WIDTH  = 3'd6,
      CSR_HEIGHT = 3'd7
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

endpackage

// ===== hdl/rkc_ram.sv =====
module rkc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/rgb_kernel_convolution.sv =====
// Channel   | Direction | Beat contents
// req_      | in        | command, in_red, in_green, in_blue
// rsp_      | out       | out_red, out_green, out_blue, frame_last
// csr_      | in        | index (0..7), 64-bit write data
//
// A beat that gives no result leaves the block idle; one that gives a result walks
// the KERNEL_SIZE*KERNEL_SIZE taps through the single read port of the line store
// (one tap per cycle), then drain, scale and output load.
// Reset is synchronous; req_ready stays low after reset and after each csr write
// until hold_ff has counted down to zero. csr_ready is always high.
// A stalled result sits in the output register while the next beat is taken.
module rgb_kernel_convolution import rkc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [0:0]  req_command,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAPS,
      ST_DRAIN,
      ST_SCALE,
      ST_OUT
   } state_type;

   // configuration
   logic [63:0]           coeff_ff [4];
   logic [SCALE_BITS-1:0] scale_ff;
   logic                  grey_ff;
   logic [11:0]           width_ff;
   logic [15:0]           height_ff;
   logic [1:0]            hold_ff;

   // derived sizes
   logic [WID_BITS-1:0]   w_ff, w_in;
   logic [ROW_BITS-1:0]   h_ff, h_in;
   logic [CNT_BITS-1:0]   total_ff, lag_ff;

   // stream counters
   state_type             state_ff, state_in;
   logic [COL_BITS-1:0]   in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RM_BITS-1:0]    in_rm_ff, in_rm_in, out_rm_ff, out_rm_in;
   logic [CNT_BITS-1:0]   in_cnt_ff, in_cnt_in, emit_ff, emit_in;

   // tap walk and datapath
   logic [KI_BITS-1:0]          tap_i_ff, tap_i_in, tap_j_ff, tap_j_in;
   logic [TAP_BITS-1:0]         tap_k_ff, tap_k_in;
   logic                        live_ff, live_in;
   logic signed [7:0]           coef_ff, coef_in;
   logic signed [SUM_BITS-1:0]  acc_ff [3], acc_in [3];
   logic [PROD_BITS-1:0]        prod_ff [3], prod_in [3];

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_pix_ff [3], rsp_pix_in [3];
   logic                  rsp_last_ff, rsp_last_in;

   // line store ports
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
   logic [PIX_BITS-1:0]   ram_rdata;
   logic [255:0]          coeff_all;

   assign req_ready      = (state_ff == ST_IDLE) && (hold_ff == 2'd0);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff[0];
   assign rsp_out_green  = rsp_pix_ff[1];
   assign rsp_out_blue   = rsp_pix_ff[2];
   assign rsp_frame_last = rsp_last_ff;
   assign coeff_all      = {coeff_ff[3], coeff_ff[2], coeff_ff[1], coeff_ff[0]};

   rkc_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({req_in_red, req_in_green, req_in_blue}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // clip the size registers to the usable range
   always_comb begin
      if (width_ff == 12'd0) begin
         w_in = WID_BITS'(1);
      end else if (WID_BITS'(width_ff) > WID_BITS'(MAX_WIDTH)) begin
         w_in = WID_BITS'(MAX_WIDTH);
      end else begin
         w_in = WID_BITS'(width_ff);
      end
      h_in = (height_ff == 16'd0) ? ROW_BITS'(1) : height_ff;
   end

   // tap address: row and column of the tap, bounds, and row slot in the store
   logic signed [ROW_BITS+1:0] tap_y;
   logic signed [WID_BITS+1:0] tap_x;
   logic [RMX_BITS-1:0]        slot_raw;
   logic [RM_BITS-1:0]         slot;
   logic                       tap_ok;

   always_comb begin
      tap_y = $signed({2'b00, out_row_ff}) + $signed((ROW_BITS+2)'(HALF))
            - $signed((ROW_BITS+2)'(tap_i_ff));
      tap_x = $signed((WID_BITS+2)'(out_col_ff)) + $signed((WID_BITS+2)'(HALF))
            - $signed((WID_BITS+2)'(tap_j_ff));
      tap_ok = (tap_y >= 0) && (tap_y < $signed({2'b00, h_ff}))
            && (tap_x >= 0) && (tap_x < $signed({2'b00, w_ff}));
      slot_raw = RMX_BITS'(out_rm_ff) + RMX_BITS'(ROWS_KEPT + HALF) - RMX_BITS'(tap_i_ff);
      if (slot_raw >= RMX_BITS'(2 * ROWS_KEPT)) begin
         slot = RM_BITS'(slot_raw - RMX_BITS'(2 * ROWS_KEPT));
      end else if (slot_raw >= RMX_BITS'(ROWS_KEPT)) begin
         slot = RM_BITS'(slot_raw - RMX_BITS'(ROWS_KEPT));
      end else begin
         slot = RM_BITS'(slot_raw);
      end
      ram_raddr = ADDR_BITS'(slot) * ADDR_BITS'(MAX_WIDTH)
                + ADDR_BITS'(tap_x[COL_BITS-1:0]);
   end

   // clamp and optional luma of the scaled sums
   logic [SUM_BITS-1:0] shifted [3];
   logic [7:0]          clamped [3];
   logic [15:0]         luma;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         shifted[c] = prod_ff[c][PROD_BITS-1:16];
         clamped[c] = (shifted[c] > SUM_BITS'(255)) ? 8'hFF : shifted[c][7:0];
      end
      luma = 16'(clamped[0]) * 16'd77 + 16'(clamped[1]) * 16'd150
           + 16'(clamped[2]) * 16'd29;
   end

   // beat handling, tap walk and output load
   logic                  frame_done, rcv_all, emit;
   logic [COL_BITS-1:0]   c_col;
   logic [ROW_BITS-1:0]   c_row;
   logic [RM_BITS-1:0]    c_rm;
   logic [CNT_BITS-1:0]   c_cnt, c_emit;

   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_rm_in     = in_rm_ff;
      in_cnt_in    = in_cnt_ff;
      emit_in      = emit_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_rm_in    = out_rm_ff;
      tap_i_in     = tap_i_ff;
      tap_j_in     = tap_j_ff;
      tap_k_in     = tap_k_ff;
      live_in      = 1'b0;
      coef_in      = coef_ff;
      prod_in      = prod_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = ADDR_BITS'(in_rm_ff) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(in_col_ff);
      frame_done   = emit_ff >= total_ff;
      c_col        = frame_done ? '0 : in_col_ff;
      c_row        = frame_done ? '0 : in_row_ff;
      c_rm         = frame_done ? '0 : in_rm_ff;
      c_cnt        = frame_done ? '0 : in_cnt_ff;
      c_emit       = frame_done ? '0 : emit_ff;
      rcv_all      = c_row >= h_ff;
      emit         = 1'b0;

      // accumulate the tap read last cycle
      for (int c = 0; c < 3; c++) begin
         acc_in[c] = acc_ff[c];
         if (live_ff) begin
            acc_in[c] = acc_ff[c] + SUM_BITS'(coef_ff
                      * $signed({1'b0, ram_rdata[8*(2-c) +: 8]}));
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_command == CMD_PIXEL) begin
                  if (!rcv_all) begin
                     ram_we    = 1'b1;
                     ram_waddr = ADDR_BITS'(c_rm) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(c_col);
                     emit      = (c_cnt >= lag_ff) && (c_emit + lag_ff <= c_cnt);
                     c_cnt     = c_cnt + 1'b1;
                     if (WID_BITS'(c_col) + 1'b1 >= w_ff) begin
                        c_col = '0;
                        c_row = c_row + 1'b1;
                        c_rm  = (c_rm == RM_BITS'(ROWS_KEPT - 1)) ? '0 : c_rm + 1'b1;
                     end else begin
                        c_col = c_col + 1'b1;
                     end
                  end
               end else begin
                  emit = rcv_all;
               end
               in_col_in = c_col;
               in_row_in = c_row;
               in_rm_in  = c_rm;
               in_cnt_in = c_cnt;
               emit_in   = c_emit;
               if (frame_done) begin
                  out_col_in = '0;
                  out_row_in = '0;
                  out_rm_in  = '0;
               end
               if (emit) begin
                  state_in = ST_TAPS;
                  tap_i_in = '0;
                  tap_j_in = '0;
                  tap_k_in = '0;
                  for (int c = 0; c < 3; c++) begin
                     acc_in[c] = '0;
                  end
               end
            end
         end
         ST_TAPS: begin
            live_in  = tap_ok;
            coef_in  = $signed(coeff_all[8*tap_k_ff +: 8]);
            tap_k_in = tap_k_ff + 1'b1;
            if (tap_j_ff == KI_BITS'(KERNEL_SIZE - 1)) begin
               tap_j_in = '0;
               tap_i_in = tap_i_ff + 1'b1;
               if (tap_i_ff == KI_BITS'(KERNEL_SIZE - 1)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               tap_j_in = tap_j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            for (int c = 0; c < 3; c++) begin
               prod_in[c] = (acc_ff[c] > 0)
                          ? PROD_BITS'(acc_ff[c][SUM_BITS-2:0]) * PROD_BITS'(scale_ff)
                          : '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               for (int c = 0; c < 3; c++) begin
                  rsp_pix_in[c] = grey_ff ? luma[15:8] : clamped[c];
               end
               rsp_valid_in = 1'b1;
               rsp_last_in  = (emit_ff + 1'b1) == total_ff;
               emit_in      = emit_ff + 1'b1;
               if (WID_BITS'(out_col_ff) + 1'b1 >= w_ff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
                  out_rm_in  = (out_rm_ff == RM_BITS'(ROWS_KEPT - 1)) ? '0 : out_rm_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold all registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < 4; i++) begin
            coeff_ff[i] <= '0;
         end
         scale_ff     <= SCALE_ONE;
         grey_ff      <= 1'b0;
         width_ff     <= 12'd2048;
         height_ff    <= 16'd1;
         hold_ff      <= 2'd2;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_rm_ff     <= '0;
         in_cnt_ff    <= '0;
         emit_ff      <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_rm_ff    <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_rm_ff     <= in_rm_in;
         in_cnt_ff    <= in_cnt_in;
         emit_ff      <= emit_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_rm_ff    <= out_rm_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         // hold off input after a register write until hold_ff has counted down to zero
         hold_ff      <= (csr_valid && csr_ready) ? 2'd2
                       : (hold_ff == 2'd0) ? 2'd0 : hold_ff - 2'd1;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_COEFF0: coeff_ff[0] <= csr_data;
               CSR_COEFF1: coeff_ff[1] <= csr_data;
               CSR_COEFF2: coeff_ff[2] <= csr_data;
               CSR_COEFF3: coeff_ff[3] <= csr_data;
               CSR_SCALE:  scale_ff    <= csr_data[SCALE_BITS-1:0];
               CSR_GREY:   grey_ff     <= csr_data[0];
               CSR_WIDTH:  width_ff    <= csr_data[11:0];
               CSR_HEIGHT: height_ff   <= csr_data[15:0];
               default:    ;
            endcase
         end
      end
      // payload and derived sizes
      w_ff        <= w_in;
      h_ff        <= h_in;
      total_ff    <= CNT_BITS'(w_in) * CNT_BITS'(h_in);
      lag_ff      <= CNT_BITS'(w_in) * CNT_BITS'(HALF) + CNT_BITS'(HALF);
      tap_i_ff    <= tap_i_in;
      tap_j_ff    <= tap_j_in;
      tap_k_ff    <= tap_k_in;
      coef_ff     <= coef_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== hdl/rkc_checker.sv =====
module rkc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [0:0]  req_command,
   input logic [7:0]  req_in_red,
   input logic [7:0]  req_in_green,
   input logic [7:0]  req_in_blue,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_red,
   input logic [7:0]  rsp_out_green,
   input logic [7:0]  rsp_out_blue,
   input logic        rsp_frame_last,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [63:0] csr_data
);

   // block input right after a register write so new sizes settle
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_ready)
      else $error("req_ready high right after a csr write");

   // no result straight out of reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // hold a stalled result beat
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_out_red) && $stable(rsp_out_green)
         && $stable(rsp_out_blue) && $stable(rsp_frame_last))
      else $error("rsp payload changed while stalled");

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (.*);
